>>> design/jse_pkg.sv
// shared types, character constants and helper functions for the json string escaper
// no dependencies; imported by every module of the block
package jse_pkg;

   // character codes
   localparam logic [7:0] QUOTE_CHAR  = 8'h22;
   localparam logic [7:0] BSLASH_CHAR = 8'h5C;
   localparam logic [7:0] U_CHAR      = 8'h75;
   localparam logic [7:0] ZERO_CHAR   = 8'h30;
   localparam logic [7:0] LOWER_A     = 8'h61;
   localparam logic [7:0] CTRL_LIMIT  = 8'h20;
   localparam logic [7:0] ASCII_LIMIT = 8'h80;

   // descriptor queue geometry
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // escape class of one item
   typedef enum logic [1:0] {
      KIND_PLAIN   = 2'd0,
      KIND_SHORT   = 2'd1,
      KIND_UNICODE = 2'd2,
      KIND_EMPTY   = 2'd3
   } kind_type;

   // classified item handed from front to back
   typedef struct packed {
      kind_type   kind;
      logic [7:0] data;
      logic       open_quote;
      logic       close_quote;
   } desc_type;

   // queue status seen by the front
   typedef struct packed {
      logic push;
      logic full;
   } push_type;

   // queue head seen by the back
   typedef struct packed {
      logic     valid;
      desc_type desc;
   } head_type;

   // two-character escape letter, zero when the byte has none
   function automatic logic [7:0] short_code(input logic [7:0] b);
      logic [7:0] code;
      code = 8'h00;
      case (b)
         8'h22:   code = QUOTE_CHAR;
         8'h5C:   code = BSLASH_CHAR;
         8'h0A:   code = 8'h6E;
         8'h0D:   code = 8'h72;
         8'h09:   code = 8'h74;
         8'h08:   code = 8'h62;
         8'h0C:   code = 8'h66;
         default: code = 8'h00;
      endcase
      return code;
   endfunction

   // lower-case hex digit of one nibble
   function automatic logic [7:0] hex_digit(input logic [3:0] nib);
      logic [7:0] ch;
      if (nib < 4'd10) begin
         ch = ZERO_CHAR + {4'd0, nib};
      end else begin
         ch = LOWER_A + {4'd0, nib} - 8'd10;
      end
      return ch;
   endfunction

endpackage

>>> design/jse_front.sv
// front stage: accepts raw string bytes and classifies them into escape descriptors
// depends on jse_pkg; feeds jse_queue
module jse_front
   import jse_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_byte_value,
   input  logic       req_first_of_string,
   input  logic       req_last_of_string,
   input  logic       req_empty_string,
   input  logic       q_full,
   output push_type   push,
   output desc_type   push_desc
);

   logic     valid_ff;
   logic     valid_in;
   desc_type desc_ff;
   desc_type desc_in;
   logic [7:0] code;

   // classify the incoming item
   always_comb begin
      code = short_code(req_byte_value);
      desc_in.data        = (code != 8'h00) ? code : req_byte_value;
      desc_in.open_quote  = !req_empty_string && req_first_of_string;
      desc_in.close_quote = !req_empty_string && req_last_of_string;
      if (req_empty_string) begin
         desc_in.kind = KIND_EMPTY;
      end else if (code != 8'h00) begin
         desc_in.kind = KIND_SHORT;
      end else if (req_byte_value < CTRL_LIMIT || req_byte_value >= ASCII_LIMIT) begin
         desc_in.kind = KIND_UNICODE;
      end else begin
         desc_in.kind = KIND_PLAIN;
      end
   end

   // hand-off into the queue
   always_comb begin
      push.full = q_full;
      push.push = valid_ff && !q_full;
      req_ready = !valid_ff || !q_full;
      valid_in  = req_valid && req_ready ? 1'b1 : (push.push ? 1'b0 : valid_ff);
   end

   assign push_desc = desc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         desc_ff <= desc_in;
      end
   end

endmodule

>>> design/jse_queue.sv
// short descriptor queue between the front and the back
// depends on jse_pkg
module jse_queue
   import jse_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  push_type push,
   input  desc_type push_desc,
   input  logic     pop,
   output logic     full,
   output head_type head
);

   desc_type                 entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]   wr_ptr_ff;
   logic [QUEUE_PTR_W-1:0]   wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]   rd_ptr_ff;
   logic [QUEUE_PTR_W-1:0]   rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]   count_ff;
   logic [QUEUE_CNT_W-1:0]   count_in;

   // status and pointer updates
   always_comb begin
      full       = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
      head.valid = (count_ff != '0);
      head.desc  = entry_ff[rd_ptr_ff];
      wr_ptr_in  = push.push ? wr_ptr_ff + QUEUE_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in  = pop ? rd_ptr_ff + QUEUE_PTR_W'(1) : rd_ptr_ff;
      count_in   = count_ff + QUEUE_CNT_W'(push.push) - QUEUE_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push.push) begin
         entry_ff[wr_ptr_ff] <= push_desc;
      end
   end

   // no push into a full queue
   assert property (@(posedge clock) disable iff (reset) push.push |-> !full)
      else $error("push while queue full");

   // no pop from an empty queue
   assert property (@(posedge clock) disable iff (reset) pop |-> head.valid)
      else $error("pop while queue empty");

   // occupancy tracks the pointers
   assert property (@(posedge clock) disable iff (reset)
      (count_ff != QUEUE_CNT_W'(QUEUE_DEPTH)) |->
         (wr_ptr_ff - rd_ptr_ff) == count_ff[QUEUE_PTR_W-1:0])
      else $error("queue count out of step with pointers");

endmodule

>>> design/jse_back.sv
// back stage: walks each descriptor and emits its escaped bytes one per cycle while rsp_ready holds
// depends on jse_pkg; pops jse_queue
module jse_back
   import jse_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  head_type   head,
   output logic       pop,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_last_of_run
);

   logic [2:0] step_ff;
   logic [2:0] step_in;
   logic       valid_ff;
   logic       valid_in;
   logic [7:0] byte_ff;
   logic [7:0] byte_in;
   logic       last_ff;
   logic       last_in;
   logic       advance;
   logic [7:0] body [8];
   logic [2:0] body_len;
   logic [3:0] run_len;
   logic [2:0] rel;
   logic       is_last;

   // escape body of the head descriptor
   always_comb begin
      for (int k = 0; k < 8; k++) begin
         body[k] = QUOTE_CHAR;
      end
      body_len = 3'd1;
      case (head.desc.kind)
         KIND_PLAIN: begin
            body[0]  = head.desc.data;
            body_len = 3'd1;
         end
         KIND_SHORT: begin
            body[0]  = BSLASH_CHAR;
            body[1]  = head.desc.data;
            body_len = 3'd2;
         end
         KIND_UNICODE: begin
            body[0]  = BSLASH_CHAR;
            body[1]  = U_CHAR;
            body[2]  = ZERO_CHAR;
            body[3]  = ZERO_CHAR;
            body[4]  = hex_digit(head.desc.data[7:4]);
            body[5]  = hex_digit(head.desc.data[3:0]);
            body_len = 3'd6;
         end
         KIND_EMPTY: begin
            body_len = 3'd2;
         end
         default: begin
            body_len = 3'd1;
         end
      endcase
   end

   // pick the byte at the current step
   always_comb begin
      run_len = {1'b0, body_len} + {3'd0, head.desc.open_quote}
                + {3'd0, head.desc.close_quote};
      rel     = step_ff - {2'd0, head.desc.open_quote};
      is_last = ({1'b0, step_ff} == run_len - 4'd1);
      if (head.desc.open_quote && step_ff == 3'd0) begin
         byte_in = QUOTE_CHAR;
      end else if (rel < body_len) begin
         byte_in = body[rel];
      end else begin
         byte_in = QUOTE_CHAR;
      end
   end

   // output register and step sequencing
   always_comb begin
      advance  = !valid_ff || rsp_ready;
      pop      = advance && head.valid && is_last;
      last_in  = is_last;
      valid_in = advance ? head.valid : valid_ff;
      step_in  = step_ff;
      if (advance && head.valid) begin
         step_in = is_last ? 3'd0 : step_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         step_ff  <= 3'd0;
      end else begin
         valid_ff <= valid_in;
         step_ff  <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && head.valid) begin
         byte_ff <= byte_in;
         last_ff <= last_in;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_out_byte    = byte_ff;
   assign rsp_last_of_run = last_ff;

   // step never runs past the run of the head item
   assert property (@(posedge clock) disable iff (reset)
      head.valid |-> ({1'b0, step_ff} < run_len))
      else $error("step beyond escaped run");

   // a run ends exactly when its descriptor leaves the queue
   assert property (@(posedge clock) disable iff (reset)
      pop |=> (rsp_valid && rsp_last_of_run && step_ff == 3'd0))
      else $error("pop without closing output byte");

   // step is back at zero whenever nothing is waiting
   assert property (@(posedge clock) disable iff (reset)
      !head.valid |-> step_ff == 3'd0)
      else $error("step left mid-run with empty queue");

endmodule

>>> design/json_string_byte_escaper.sv
// top level of the json string escaper: front classifier, descriptor queue, back sequencer
// depends on jse_pkg, jse_front, jse_queue and jse_back
//
// One raw string byte comes in per item and leaves as its JSON-escaped text, one byte per
// cycle on the rsp_ channel while rsp_ready holds, with rsp_last_of_run marking the final
// byte of each item. An item produces one output byte for printable ASCII, two for a short
// escape or an empty string, six for a \u00xx escape, plus one for each opening or closing
// quote, so 1 to 8 bytes in all; the back sequencer emits them through its single output
// byte register. Items are taken one per cycle while the four-entry descriptor queue has
// room, so bursts of input are absorbed while long escapes drain. An accepted item passes
// through the front register, a queue entry and the back output byte register in order.
module json_string_byte_escaper
   import jse_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_byte_value,
   input  logic       req_first_of_string,
   input  logic       req_last_of_string,
   input  logic       req_empty_string,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_last_of_run
);

   push_type push;
   desc_type push_desc;
   head_type head;
   logic     q_full;
   logic     pop;

   // accept and classify
   jse_front u_front (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_byte_value      (req_byte_value),
      .req_first_of_string (req_first_of_string),
      .req_last_of_string  (req_last_of_string),
      .req_empty_string    (req_empty_string),
      .q_full              (q_full),
      .push                (push),
      .push_desc           (push_desc)
   );

   // decoupling queue
   jse_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_desc (push_desc),
      .pop       (pop),
      .full      (q_full),
      .head      (head)
   );

   // emit escaped bytes
   jse_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head            (head),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule

>>> sim/tb.sv
// self-checking testbench for json_string_byte_escaper: directed and random string bytes
// with random stalls on both sides, checked against a cycle-free escaping predictor
// depends on jse_pkg and json_string_byte_escaper
module tb;
   import jse_pkg::*;

   localparam int  HALF_PERIOD  = 6;
   localparam int  RESET_CYCLES = 12;
   localparam int  RANDOM_ITEMS = 380;
   localparam int  LONG_HOLD    = 200;
   localparam int  BURST_ITEMS  = 24;
   localparam int  DRAIN_CYCLES = 16;
   localparam time RUN_LIMIT    = 6_000_000;

   // control bytes with a two-character escape, plus DEL, which passes unescaped
   localparam logic [7:0] LF_BYTE  = 8'h0A;
   localparam logic [7:0] CR_BYTE  = 8'h0D;
   localparam logic [7:0] TAB_BYTE = 8'h09;
   localparam logic [7:0] BS_BYTE  = 8'h08;
   localparam logic [7:0] FF_BYTE  = 8'h0C;
   localparam logic [7:0] DEL_BYTE = 8'h7F;

   // one raw string byte with its markers
   typedef struct packed {
      logic [7:0] byte_value;
      logic       opens;
      logic       closes;
      logic       is_empty;
   } str_byte_type;

   // one byte of escaped text with its end-of-run flag
   typedef struct packed {
      logic [7:0] text;
      logic       run_end;
   } esc_char_type;

   // expected escaped text, built per accepted item and consumed per output byte
   class escaped_text_checker_type;
      esc_char_type pending_text[$];
      int           mismatches;
      string        hex_digits;

      function new();
         mismatches = 0;
         hex_digits = "0123456789abcdef";
      endfunction

      function int pending();
         return pending_text.size();
      endfunction

      // json escape of one item, quotes included
      function void predict_escape(str_byte_type it);
         logic [7:0] run[$];
         logic [7:0] letter;
         logic [7:0] b;
         b = it.byte_value;
         letter = 8'h00;
         if (it.is_empty) begin
            run.push_back(QUOTE_CHAR);
            run.push_back(QUOTE_CHAR);
         end else begin
            if (it.opens) run.push_back(QUOTE_CHAR);
            case (b)
               QUOTE_CHAR:  letter = QUOTE_CHAR;
               BSLASH_CHAR: letter = BSLASH_CHAR;
               LF_BYTE:     letter = "n";
               CR_BYTE:     letter = "r";
               TAB_BYTE:    letter = "t";
               BS_BYTE:     letter = "b";
               FF_BYTE:     letter = "f";
               default:     letter = 8'h00;
            endcase
            if (letter != 8'h00) begin
               run.push_back(BSLASH_CHAR);
               run.push_back(letter);
            end else if (b < CTRL_LIMIT || b >= ASCII_LIMIT) begin
               run.push_back(BSLASH_CHAR);
               run.push_back(U_CHAR);
               run.push_back(ZERO_CHAR);
               run.push_back(ZERO_CHAR);
               run.push_back(hex_digits[b[7:4]]);
               run.push_back(hex_digits[b[3:0]]);
            end else begin
               run.push_back(b);
            end
            if (it.closes) run.push_back(QUOTE_CHAR);
         end
         foreach (run[i]) pending_text.push_back({run[i], i == run.size() - 1});
      endfunction

      task report_mismatch(string what);
         $display("%0t mismatch: %s", $time, what);
         mismatches++;
      endtask

      // compare one output byte with the oldest expectation
      task check_byte(logic [7:0] got, logic got_end);
         esc_char_type want;
         if (pending_text.size() == 0) begin
            report_mismatch($sformatf("unexpected byte %02h last %0b", got, got_end));
            return;
         end
         want = pending_text.pop_front();
         if (got !== want.text)
            report_mismatch($sformatf("byte %02h, wanted %02h", got, want.text));
         if (got_end !== want.run_end)
            report_mismatch($sformatf("last_of_run %0b, wanted %0b", got_end, want.run_end));
      endtask
   endclass

   logic       clock;
   logic       reset               = 1'b1;
   logic       req_valid           = 1'b0;
   logic       req_ready;
   logic [7:0] req_byte_value      = 8'h00;
   logic       req_first_of_string = 1'b0;
   logic       req_last_of_string  = 1'b0;
   logic       req_empty_string    = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready           = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_last_of_run;

   escaped_text_checker_type checker_q;
   int items_sent   = 0;
   int hold_orders  = 0;
   int no_gap_left  = 0;

   logic [7:0] specials [7] = '{QUOTE_CHAR, BSLASH_CHAR, LF_BYTE, CR_BYTE,
                                TAB_BYTE, BS_BYTE, FF_BYTE};

   // extremes, every escape class and every marker combination but closing-only on an empty string
   str_byte_type directed_items [22] = '{
      {8'h41,       1'b1, 1'b1, 1'b0},
      {CTRL_LIMIT,  1'b1, 1'b0, 1'b0},
      {8'h7E,       1'b0, 1'b0, 1'b0},
      {DEL_BYTE,    1'b0, 1'b1, 1'b0},
      {QUOTE_CHAR,  1'b1, 1'b0, 1'b0},
      {BSLASH_CHAR, 1'b0, 1'b0, 1'b0},
      {LF_BYTE,     1'b0, 1'b0, 1'b0},
      {CR_BYTE,     1'b0, 1'b0, 1'b0},
      {TAB_BYTE,    1'b0, 1'b0, 1'b0},
      {BS_BYTE,     1'b0, 1'b0, 1'b0},
      {FF_BYTE,     1'b0, 1'b1, 1'b0},
      {8'h00,       1'b1, 1'b1, 1'b0},
      {8'h1F,       1'b0, 1'b0, 1'b0},
      {8'h0B,       1'b0, 1'b0, 1'b0},
      {ASCII_LIMIT, 1'b0, 1'b0, 1'b0},
      {8'hFF,       1'b1, 1'b1, 1'b0},
      {8'hAB,       1'b0, 1'b0, 1'b0},
      {8'hC5,       1'b0, 1'b1, 1'b0},
      {8'h00,       1'b0, 1'b0, 1'b1},
      {8'hFF,       1'b1, 1'b1, 1'b1},
      {8'h5A,       1'b1, 1'b0, 1'b1},
      {QUOTE_CHAR,  1'b1, 1'b1, 1'b1}
   };

   json_string_byte_escaper uut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_byte_value      (req_byte_value),
      .req_first_of_string (req_first_of_string),
      .req_last_of_string  (req_last_of_string),
      .req_empty_string    (req_empty_string),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_out_byte        (rsp_out_byte),
      .rsp_last_of_run     (rsp_last_of_run)
   );

   initial begin
      clock = 1'b0;
      forever #(HALF_PERIOD) clock = ~clock;
   end

   // idle length: mostly none, often short, now and then long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // raw byte drawn across printable, escaped, control and high ranges
   function automatic logic [7:0] pick_byte();
      int r;
      r = $urandom_range(0, 9);
      case (r)
         0, 1, 2, 3: return 8'($urandom_range(32, 126));
         4:          return specials[$urandom_range(0, 6)];
         5:          return 8'($urandom_range(0, 31));
         6:          return 8'($urandom_range(128, 255));
         7:          return ($urandom_range(0, 1) != 0) ? DEL_BYTE : CTRL_LIMIT;
         default:    return 8'($urandom());
      endcase
   endfunction

   // present one item and wait for it to be taken
   task automatic send_item(input str_byte_type it);
      req_valid           <= 1'b1;
      req_byte_value      <= it.byte_value;
      req_first_of_string <= it.opens;
      req_last_of_string  <= it.closes;
      req_empty_string    <= it.is_empty;
      do @(posedge clock); while (!req_ready);
      checker_q.predict_escape(it);
      items_sent++;
   endtask

   // optional idle gap, then one item
   task automatic offer_item(input str_byte_type it);
      int gap;
      if (no_gap_left > 0) begin
         gap = 0;
         no_gap_left--;
      end else begin
         gap = pick_gap();
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      send_item(it);
   endtask

   // stimulus
   initial begin
      str_byte_type it;
      int           len;
      int           r;
      bit           held;
      bit           drained;
      held    = 1'b0;
      drained = 1'b0;
      checker_q = new();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_items[i]) offer_item(directed_items[i]);

      while (items_sent < $size(directed_items) + RANDOM_ITEMS) begin
         // long receiver hold with the sender pushing on, so the queue fills
         if (!held && items_sent > 140) begin
            held = 1'b1;
            hold_orders <= hold_orders + 1;
            no_gap_left = BURST_ITEMS;
         end
         // sender pause until the output has fully drained
         if (!drained && items_sent > 270) begin
            drained = 1'b1;
            req_valid <= 1'b0;
            do @(posedge clock); while (checker_q.pending() != 0);
         end
         r = $urandom_range(0, 99);
         if (r < 8) begin
            // empty string, other fields random
            it = {8'($urandom()), 1'($urandom()), 1'($urandom()), 1'b1};
            offer_item(it);
         end else if (r < 18) begin
            // noise: markers with no string structure
            it = {pick_byte(), 1'($urandom()), 1'($urandom()), 1'b0};
            offer_item(it);
         end else begin
            // well-formed string with random content
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 6);
            for (int k = 0; k < len; k++) begin
               it = {pick_byte(), k == 0, k == len - 1, 1'b0};
               offer_item(it);
            end
         end
      end

      req_valid <= 1'b0;
      do @(posedge clock); while (checker_q.pending() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (checker_q.mismatches == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   // receiver: random back-pressure, long hold on request
   initial begin
      int gap;
      int holds_served;
      holds_served = 0;
      do @(posedge clock); while (reset);
      forever begin
         if (hold_orders != holds_served) begin
            holds_served++;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else begin
            gap = pick_gap();
            if (gap > 0) begin
               rsp_ready <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         rsp_ready <= 1'b1;
         repeat (($urandom_range(0, 9) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 8))
            @(posedge clock);
      end
   end

   // output monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         checker_q.check_byte(rsp_out_byte, rsp_last_of_run);
   end

   // watchdog
   initial begin
      #(RUN_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
